/* rtl/fpccs_pkg.sv */
// Shared types and constants of the four-point cell color sampler.
`default_nettype none
package fpccs_pkg;

    localparam int DEF_MAX_IMAGE_WIDTH  = 128;
    localparam int DEF_MAX_IMAGE_HEIGHT = 128;

    localparam int PIXEL_W   = 24;
    localparam int MUL_OP_W  = 11;
    localparam int MUL_ADD_W = 21;
    localparam int MUL_RES_W = 24;

    // configuration register indexes
    localparam logic [2:0] REG_CELL_SIZE    = 3'd0;
    localparam logic [2:0] REG_ORIGIN_X     = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Y     = 3'd2;
    localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd3;
    localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd4;
    localparam logic [2:0] REG_GRID_WIDTH   = 3'd5;

    // command codes
    localparam logic CMD_STORE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // one multiply-add request: a * b + c
    typedef struct packed {
        logic [MUL_OP_W-1:0]         a;
        logic [MUL_OP_W-1:0]         b;
        logic signed [MUL_ADD_W-1:0] c;
    } mul_req_t;

endpackage
`default_nettype wire

/* rtl/fpccs_pixel_ram.sv */
// Single-port RGB pixel store with registered read data.
`default_nettype none
module fpccs_pixel_ram #(
    parameter int DEPTH = 16384,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                           clk,
    input  wire logic                           we,
    input  wire logic [AW-1:0]                  addr,
    input  wire logic [fpccs_pkg::PIXEL_W-1:0]  wdata,
    output logic      [fpccs_pkg::PIXEL_W-1:0]  rdata
);
    import fpccs_pkg::*;

    logic [PIXEL_W-1:0] mem [DEPTH];
    logic [PIXEL_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        else
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/fpccs_mul_unit.sv */
// Shared multiply-add unit, one registered a * b + c per cycle.
`default_nettype none
module fpccs_mul_unit (
    input  wire logic                                clk,
    input  wire fpccs_pkg::mul_req_t                 req,
    output logic signed [fpccs_pkg::MUL_RES_W-1:0]   result
);
    import fpccs_pkg::*;

    logic [2*MUL_OP_W-1:0]        prod;
    logic signed [MUL_RES_W-1:0]  result_reg;
    logic signed [MUL_RES_W-1:0]  result_next;

    always_comb
    begin
        prod        = req.a * req.b;
        result_next = $signed({{(MUL_RES_W-2*MUL_OP_W){1'b0}}, prod})
                    + $signed({{(MUL_RES_W-MUL_ADD_W){req.c[MUL_ADD_W-1]}}, req.c});
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result = result_reg;

endmodule
`default_nettype wire

/* rtl/four_point_cell_color_sampler.sv */
// Top level of the four-point cell color sampler: sequencer, registers, sampling datapath.
`default_nettype none
// Command-style block. A transaction is taken at a clock edge with start high and busy low.
// A store command (cmd 0) writes one RGB pixel into the on-chip store in that single cycle
// and leaves busy low, so stores can be issued every cycle. A sample command (cmd 1) keeps
// busy high through passes of the one shared multiply-add unit (cell x, cell y and the
// linear cell index, then a drain of its output register), then through a pass that clamps
// the four sample points and reads them one after another from the single-port pixel
// store (clamp stage, read stage, accumulate stage). done pulses for one cycle in the first
// cycle with busy low, carrying cell_index and the three channel averages;
// the receiver cannot stall, so the result must be taken in that cycle. A new command may
// be given in that same cycle. A sample request while image_width or image_height is zero
// gives no result and does not raise busy. Configuration writes (wr_en, wr_index, wr_data)
// take effect at once and must only be made while the block is idle. Pixels that were
// never stored read back as unknown values. The store has no reset and no clearing pass.
module four_point_cell_color_sampler #(
    parameter int MAX_IMAGE_WIDTH  = fpccs_pkg::DEF_MAX_IMAGE_WIDTH,
    parameter int MAX_IMAGE_HEIGHT = fpccs_pkg::DEF_MAX_IMAGE_HEIGHT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [15:0] wr_data,
    // command
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cmd,
    input  wire logic [6:0]  pixel_x,
    input  wire logic [6:0]  pixel_y,
    input  wire logic [7:0]  red_in,
    input  wire logic [7:0]  green_in,
    input  wire logic [7:0]  blue_in,
    input  wire logic [9:0]  cell_x,
    input  wire logic [9:0]  cell_y,
    // result
    output logic             done,
    output logic [19:0]      cell_index,
    output logic [7:0]       red_avg,
    output logic [7:0]       green_avg,
    output logic [7:0]       blue_avg
);
    import fpccs_pkg::*;

    localparam int DEPTH = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAX_IMAGE_WIDTH);
    localparam int YW    = $clog2(MAX_IMAGE_HEIGHT);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAX_IMAGE_WIDTH);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_READ = 2'd2;

    // ---------------- configuration registers ----------------
    logic [7:0]  cell_size_reg;
    logic [15:0] origin_x_reg;
    logic [15:0] origin_y_reg;
    logic [7:0]  image_width_reg;
    logic [7:0]  image_height_reg;
    logic [10:0] grid_width_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cell_size_reg    <= 8'd16;
            origin_x_reg     <= 16'd0;
            origin_y_reg     <= 16'd0;
            image_width_reg  <= 8'd128;
            image_height_reg <= 8'd128;
            grid_width_reg   <= 11'd64;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_CELL_SIZE:    cell_size_reg    <= wr_data[7:0];
                REG_ORIGIN_X:     origin_x_reg     <= wr_data;
                REG_ORIGIN_Y:     origin_y_reg     <= wr_data;
                REG_IMAGE_WIDTH:  image_width_reg  <= wr_data[7:0];
                REG_IMAGE_HEIGHT: image_height_reg <= wr_data[7:0];
                REG_GRID_WIDTH:   grid_width_reg   <= wr_data[10:0];
                default: ;
            endcase
        end
    end

    // ---------------- derived constants of the cell ----------------
    logic [7:0] near_off;
    logic [7:0] far_off;
    logic [9:0] size_x3;
    logic [7:0] w_eff;
    logic [7:0] h_eff;
    logic [7:0] lim_x;
    logic [7:0] lim_y;
    logic       empty_image;

    always_comb
    begin
        size_x3     = {2'b00, cell_size_reg} + {1'b0, cell_size_reg, 1'b0};
        near_off    = {2'b00, cell_size_reg[7:2]};
        far_off     = size_x3[9:2];
        // clamp extent is the register limited to the store geometry
        w_eff       = (32'(image_width_reg) < MAX_IMAGE_WIDTH) ? image_width_reg
                                                               : 8'(MAX_IMAGE_WIDTH);
        h_eff       = (32'(image_height_reg) < MAX_IMAGE_HEIGHT) ? image_height_reg
                                                                 : 8'(MAX_IMAGE_HEIGHT);
        lim_x       = w_eff - 8'd1;
        lim_y       = h_eff - 8'd1;
        empty_image = (image_width_reg == 8'd0) || (image_height_reg == 8'd0);
    end

    // ---------------- sequencer ----------------
    logic [1:0] state_reg, state_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       accept;
    logic       accept_store;
    logic       accept_sample;

    assign busy          = (state_reg != S_IDLE);
    assign accept        = start && !busy;
    assign accept_store  = accept && (cmd == CMD_STORE);
    assign accept_sample = accept && (cmd == CMD_SAMPLE) && !empty_image;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept_sample)
                begin
                    state_next = S_MUL;
                    cnt_next   = 3'd0;
                end
            end
            S_MUL:
            begin
                if (cnt_reg == 3'd3)
                begin
                    state_next = S_READ;
                    cnt_next   = 3'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            S_READ:
            begin
                if (cnt_reg == 3'd5)
                begin
                    state_next = S_IDLE;
                    cnt_next   = 3'd0;
                end
                else
                begin
                    cnt_next = cnt_reg + 3'd1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                cnt_next   = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // ---------------- captured cell coordinates ----------------
    logic [9:0] cx_reg;
    logic [9:0] cy_reg;

    always_ff @(posedge clk)
    begin
        if (accept_sample)
        begin
            cx_reg <= cell_x;
            cy_reg <= cell_y;
        end
    end

    // ---------------- shared multiply-add ----------------
    // step 0: cx*size - origin_x, step 1: cy*size - origin_y, step 2: cy*grid_width + cx
    mul_req_t                    mul_req;
    logic signed [MUL_RES_W-1:0] mul_result;

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:
            begin
                mul_req.a = {1'b0, cx_reg};
                mul_req.b = {3'b000, cell_size_reg};
                mul_req.c = $signed(MUL_ADD_W'(0) - MUL_ADD_W'(origin_x_reg));
            end
            2'd1:
            begin
                mul_req.a = {1'b0, cy_reg};
                mul_req.b = {3'b000, cell_size_reg};
                mul_req.c = $signed(MUL_ADD_W'(0) - MUL_ADD_W'(origin_y_reg));
            end
            default:
            begin
                mul_req.a = {1'b0, cy_reg};
                mul_req.b = grid_width_reg;
                mul_req.c = $signed(MUL_ADD_W'(cx_reg));
            end
        endcase
    end

    fpccs_mul_unit u_mul (
        .clk    (clk),
        .req    (mul_req),
        .result (mul_result)
    );

    logic signed [19:0] base_x_reg;
    logic signed [19:0] base_y_reg;
    logic [19:0]        idx_reg;

    // unit output is registered and arrives in the cycle after its request
    always_ff @(posedge clk)
    begin
        if (state_reg == S_MUL)
        begin
            if (cnt_reg == 3'd1)
            begin
                base_x_reg <= mul_result[19:0];
            end
            if (cnt_reg == 3'd2)
            begin
                base_y_reg <= mul_result[19:0];
            end
            if (cnt_reg == 3'd3)
            begin
                idx_reg <= mul_result[19:0];
            end
        end
    end

    // ---------------- clamp stage ----------------
    logic signed [20:0] vx;
    logic signed [20:0] vy;
    logic [7:0]         cx8;
    logic [7:0]         cy8;
    logic [XW-1:0]      lx_reg;
    logic [YW-1:0]      ly_reg;

    always_comb
    begin
        // sample k: bit 0 selects far column, bit 1 selects far row
        vx = {base_x_reg[19], base_x_reg}
           + $signed({13'd0, (cnt_reg[0] ? far_off : near_off)});
        vy = {base_y_reg[19], base_y_reg}
           + $signed({13'd0, (cnt_reg[1] ? far_off : near_off)});
        if (vx[20])
        begin
            cx8 = 8'd0;
        end
        else if (vx > $signed({13'd0, lim_x}))
        begin
            cx8 = lim_x;
        end
        else
        begin
            cx8 = vx[7:0];
        end
        if (vy[20])
        begin
            cy8 = 8'd0;
        end
        else if (vy > $signed({13'd0, lim_y}))
        begin
            cy8 = lim_y;
        end
        else
        begin
            cy8 = vy[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_READ) && (cnt_reg < 3'd4))
        begin
            lx_reg <= XW'(cx8);
            ly_reg <= YW'(cy8);
        end
    end

    // ---------------- pixel store port ----------------
    logic                ram_we;
    logic [AW-1:0]       ram_addr;
    logic [PIXEL_W-1:0]  ram_wdata;
    logic [PIXEL_W-1:0]  ram_rdata;

    always_comb
    begin
        ram_we    = accept_store && (32'(pixel_x) < MAX_IMAGE_WIDTH)
                                 && (32'(pixel_y) < MAX_IMAGE_HEIGHT);
        ram_wdata = {red_in, green_in, blue_in};
        if (ram_we)
        begin
            ram_addr = AW'(pixel_y) * ROW_STRIDE + AW'(pixel_x);
        end
        else
        begin
            ram_addr = AW'(ly_reg) * ROW_STRIDE + AW'(lx_reg);
        end
    end

    fpccs_pixel_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // ---------------- accumulate and result ----------------
    logic [9:0] sum_r_reg, sum_g_reg, sum_b_reg;
    logic [9:0] sum_r_next, sum_g_next, sum_b_next;
    logic       acc_en;
    logic       done_reg;
    logic [7:0] red_avg_reg, green_avg_reg, blue_avg_reg;

    always_comb
    begin
        acc_en = (state_reg == S_READ) && (cnt_reg >= 3'd2);
        if (cnt_reg == 3'd2)
        begin
            // first sample of the cell restarts the sums
            sum_r_next = {2'b00, ram_rdata[23:16]};
            sum_g_next = {2'b00, ram_rdata[15:8]};
            sum_b_next = {2'b00, ram_rdata[7:0]};
        end
        else
        begin
            sum_r_next = sum_r_reg + {2'b00, ram_rdata[23:16]};
            sum_g_next = sum_g_reg + {2'b00, ram_rdata[15:8]};
            sum_b_next = sum_b_reg + {2'b00, ram_rdata[7:0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc_en)
        begin
            sum_r_reg <= sum_r_next;
            sum_g_reg <= sum_g_next;
            sum_b_reg <= sum_b_next;
        end
        if (acc_en && (cnt_reg == 3'd5))
        begin
            red_avg_reg   <= sum_r_next[9:2];
            green_avg_reg <= sum_g_next[9:2];
            blue_avg_reg  <= sum_b_next[9:2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_READ) && (cnt_reg == 3'd5);
        end
    end

    assign done       = done_reg;
    assign cell_index = idx_reg;
    assign red_avg    = red_avg_reg;
    assign green_avg  = green_avg_reg;
    assign blue_avg   = blue_avg_reg;

    // ---------------- assertions ----------------
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (state_reg == S_IDLE))
        else $error("result strobe while sequencer active");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept_sample |=> busy)
        else $error("sample transaction did not raise busy");

    a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_IDLE))
        else $error("pixel store written during a sample");

    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_READ && cnt_reg == 3'd5))
        else $error("result strobe without a finished read pass");

endmodule
`default_nettype wire

/* sim/cell_color_check_pkg.sv */
`timescale 1ns / 100ps
// Transaction types and the scoreboard that predicts cell color averages.
package cell_color_check_pkg;
    import fpccs_pkg::*;

    localparam int STORE_COLS          = DEF_MAX_IMAGE_WIDTH;
    localparam int STORE_ROWS          = DEF_MAX_IMAGE_HEIGHT;
    localparam int MISMATCH_REPORT_MAX = 10;

    typedef struct packed {
        logic       cmd;
        logic [6:0] pixel_x;
        logic [6:0] pixel_y;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [9:0] cell_x;
        logic [9:0] cell_y;
    } sampler_cmd_t;

    typedef struct packed {
        logic [19:0] cell_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } cell_color_t;

    typedef struct packed {
        logic [7:0]  cell_size;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [7:0]  image_width;
        logic [7:0]  image_height;
        logic [10:0] grid_width;
    } sampler_cfg_t;

    class cell_color_scoreboard;
        logic [23:0] pixel_mem [STORE_COLS * STORE_ROWS];
        bit          loaded [STORE_COLS * STORE_ROWS];
        logic [7:0]  cell_size;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [7:0]  image_width;
        logic [7:0]  image_height;
        logic [10:0] grid_width;
        cell_color_t expected_colors [$];
        int          mismatch_count;

        function new();
            cell_size      = 8'd16;
            origin_x       = '0;
            origin_y       = '0;
            image_width    = 8'd128;
            image_height   = 8'd128;
            grid_width     = 11'd64;
            mismatch_count = 0;
        endfunction

        function void set_register(logic [2:0] index, logic [15:0] value);
            case (index)
                REG_CELL_SIZE:    cell_size    = value[7:0];
                REG_ORIGIN_X:     origin_x     = value;
                REG_ORIGIN_Y:     origin_y     = value;
                REG_IMAGE_WIDTH:  image_width  = value[7:0];
                REG_IMAGE_HEIGHT: image_height = value[7:0];
                REG_GRID_WIDTH:   grid_width   = value[10:0];
                default:          ;
            endcase
        endfunction

        function int clamp_point(int v, int limit);
            if (v < 0)
                return 0;
            if (v > limit - 1)
                return limit - 1;
            return v;
        endfunction

        function bit image_empty();
            return (image_width == 8'd0) || (image_height == 8'd0);
        endfunction

        // Store address of sample point k of a cell under the current settings.
        function int point_addr(sampler_cmd_t item, int k);
            int w;
            int h;
            int size;
            int near_off;
            int far_off;
            int px;
            int py;

            w        = (int'(image_width) < STORE_COLS) ? int'(image_width) : STORE_COLS;
            h        = (int'(image_height) < STORE_ROWS) ? int'(image_height) : STORE_ROWS;
            size     = int'(cell_size);
            near_off = size / 4;
            far_off  = (3 * size) / 4;
            px       = clamp_point(int'(item.cell_x) * size - int'(origin_x)
                                   + (k[0] ? far_off : near_off), w);
            py       = clamp_point(int'(item.cell_y) * size - int'(origin_y)
                                   + (k[1] ? far_off : near_off), h);
            return py * STORE_COLS + px;
        endfunction

        // First pixel a sample would read that was never stored, or -1.
        function int unloaded_point(sampler_cmd_t item);
            int addr;

            if (item.cmd == CMD_STORE || image_empty())
                return -1;
            for (int k = 0; k < 4; k++) begin
                addr = point_addr(item, k);
                if (!loaded[addr])
                    return addr;
            end
            return -1;
        endfunction

        // Stores update the pixel copy; samples queue the expected averages.
        function void note_input(sampler_cmd_t item);
            int          addr;
            int          k;
            int          sum_r;
            int          sum_g;
            int          sum_b;
            logic [23:0] rgb;
            logic [31:0] index_full;
            cell_color_t want;

            if (item.cmd == CMD_STORE) begin
                addr            = int'(item.pixel_y) * STORE_COLS + int'(item.pixel_x);
                pixel_mem[addr] = {item.red, item.green, item.blue};
                loaded[addr]    = 1'b1;
                return;
            end

            if (image_empty())
                return;

            sum_r = 0;
            sum_g = 0;
            sum_b = 0;
            for (k = 0; k < 4; k++) begin
                rgb   = pixel_mem[point_addr(item, k)];
                sum_r += int'(rgb[23:16]);
                sum_g += int'(rgb[15:8]);
                sum_b += int'(rgb[7:0]);
            end

            index_full      = int'(item.cell_y) * int'(grid_width) + int'(item.cell_x);
            want.cell_index = index_full[19:0];
            want.red        = 8'(sum_r / 4);
            want.green      = 8'(sum_g / 4);
            want.blue       = 8'(sum_b / 4);
            expected_colors = {expected_colors, want};
        endfunction

        function void check_result(cell_color_t got);
            cell_color_t want;

            if (expected_colors.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MISMATCH_REPORT_MAX)
                    $display("%0t: unexpected result index %0d rgb %h %h %h", $time,
                             got.cell_index, got.red, got.green, got.blue);
                return;
            end
            want = expected_colors.pop_front();
            if (got.cell_index !== want.cell_index || got.red !== want.red ||
                got.green !== want.green || got.blue !== want.blue) begin
                mismatch_count++;
                if (mismatch_count <= MISMATCH_REPORT_MAX)
                    $display("%0t: mismatch, expected index %0d rgb %h %h %h, got index %0d rgb %h %h %h",
                             $time, want.cell_index, want.red, want.green, want.blue,
                             got.cell_index, got.red, got.green, got.blue);
            end
        endfunction

        function int outstanding();
            return expected_colors.size();
        endfunction
    endclass

endpackage

/* sim/tb_four_point_cell_color_sampler.sv */
`timescale 1ns / 100ps
// Top-level testbench of the four-point cell color sampler.
module tb_four_point_cell_color_sampler;
    import fpccs_pkg::*;
    import cell_color_check_pkg::*;

    localparam int CYCLE_LIMIT     = 1_000_000;
    localparam int SETTLE_CYCLES   = 16;     // margin to finish a sample: its busy phase and its done strobe
    localparam int PHASE_COUNT     = 12;
    localparam int ITEMS_PER_PHASE = 135;
    localparam int MAX_GAP         = 14;     // longer than one sample so gaps hit every phase

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        wr_en     = 1'b0;
    logic [2:0]  wr_index  = '0;
    logic [15:0] wr_data   = '0;
    logic        start     = 1'b0;
    logic        cmd       = CMD_STORE;
    logic [6:0]  pixel_x   = '0;
    logic [6:0]  pixel_y   = '0;
    logic [7:0]  red_in    = '0;
    logic [7:0]  green_in  = '0;
    logic [7:0]  blue_in   = '0;
    logic [9:0]  cell_x    = '0;
    logic [9:0]  cell_y    = '0;
    logic        busy;
    logic        done;
    logic [19:0] cell_index;
    logic [7:0]  red_avg;
    logic [7:0]  green_avg;
    logic [7:0]  blue_avg;

    int          cycle_count = 0;
    int          gap_percent = 9;
    int          items_sent  = 0;
    cell_color_scoreboard color_check;

    four_point_cell_color_sampler i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .cell_x     (cell_x),
        .cell_y     (cell_y),
        .done       (done),
        .cell_index (cell_index),
        .red_avg    (red_avg),
        .green_avg  (green_avg),
        .blue_avg   (blue_avg)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Result monitor. done lasts one cycle and cannot be held off, so every
    // strobe is a finished transaction. Outputs are read before this edge's
    // updates land, i.e. the values of the cycle that just ended.
    always @(posedge clk)
    begin
        if (rst_n && done)
            color_check.check_result(cell_color_t'{cell_index, red_avg, green_avg, blue_avg});
    end

    // Watchdog: a hung handshake or a lost result ends up here.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Present one command and hold it until the edge where busy is low.
    // An optional gap with start low goes first; start is never lowered and
    // raised in the same step, back-to-back commands keep it high.
    task automatic drive_command(input sampler_cmd_t item);
        if ($urandom_range(0, 99) < gap_percent) begin
            start <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
        end
        start    <= 1'b1;
        cmd      <= item.cmd;
        pixel_x  <= item.pixel_x;
        pixel_y  <= item.pixel_y;
        red_in   <= item.red;
        green_in <= item.green;
        blue_in  <= item.blue;
        cell_x   <= item.cell_x;
        cell_y   <= item.cell_y;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        // accepted at this edge
        color_check.note_input(item);
        items_sent++;
    endtask

    function automatic sampler_cmd_t make_store(input int x, input int y,
                                                input int r, input int g, input int b);
        sampler_cmd_t item;
        item         = '0;
        item.cmd     = CMD_STORE;
        item.pixel_x = 7'(x);
        item.pixel_y = 7'(y);
        item.red     = 8'(r);
        item.green   = 8'(g);
        item.blue    = 8'(b);
        return item;
    endfunction

    // The pixel store powers up unknown: a sample only reads loaded pixels,
    // so any pixel it would read that was never stored gets stored first.
    task automatic send_command(input sampler_cmd_t item);
        int addr;
        addr = color_check.unloaded_point(item);
        while (addr >= 0) begin
            drive_command(make_store(addr % STORE_COLS, addr / STORE_COLS,
                                     $urandom_range(0, 255), $urandom_range(0, 255),
                                     $urandom_range(0, 255)));
            addr = color_check.unloaded_point(item);
        end
        drive_command(item);
    endtask

    // Stop sending, wait for every expected result, then let the block settle
    // so that a trailing store or an empty-image sample is surely finished.
    task automatic drain_results();
        start <= 1'b0;
        while (color_check.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // wr_en stays high across consecutive writes; apply_config drops it.
    task automatic write_register(input logic [2:0] index, input logic [15:0] value);
        wr_en    <= 1'b1;
        wr_index <= index;
        wr_data  <= value;
        @(posedge clk);
        color_check.set_register(index, value);
    endtask

    // Only called while idle: after reset or after drain_results.
    task automatic apply_config(input sampler_cfg_t cfg);
        write_register(REG_CELL_SIZE,    16'(cfg.cell_size));
        write_register(REG_ORIGIN_X,     cfg.origin_x);
        write_register(REG_ORIGIN_Y,     cfg.origin_y);
        write_register(REG_IMAGE_WIDTH,  16'(cfg.image_width));
        write_register(REG_IMAGE_HEIGHT, 16'(cfg.image_height));
        write_register(REG_GRID_WIDTH,   16'(cfg.grid_width));
        wr_en <= 1'b0;
    endtask

    function automatic sampler_cmd_t make_sample(input int cx, input int cy);
        sampler_cmd_t item;
        item        = '0;
        item.cmd    = CMD_SAMPLE;
        item.cell_x = 10'(cx);
        item.cell_y = 10'(cy);
        return item;
    endfunction

    // Corner settings: largest cell with widest grid (index wrap), zero cell
    // with far origin and oversized image, the minimum everything, empty
    // image in either axis, and a small cell on a 1024-wide grid.
    function automatic sampler_cfg_t corner_config(input int which);
        sampler_cfg_t cfg;
        case (which)
            0:       cfg = '{8'd255, 16'd0,     16'd0,     8'd128, 8'd128, 11'd2047};
            1:       cfg = '{8'd0,   16'd65535, 16'd65535, 8'd255, 8'd255, 11'd0};
            2:       cfg = '{8'd1,   16'd0,     16'd0,     8'd1,   8'd1,   11'd1};
            3:       cfg = '{8'd16,  16'd100,   16'd37,    8'd0,   8'd128, 11'd64};
            4:       cfg = '{8'd16,  16'd0,     16'd0,     8'd128, 8'd0,   11'd64};
            default: cfg = '{8'd4,   16'd3,     16'd5,     8'd128, 8'd128, 11'd1024};
        endcase
        return cfg;
    endfunction

    function automatic logic [7:0] random_extent();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5)
            return 8'd0;
        if (roll < 15)
            return 8'($urandom_range(129, 255));
        return 8'($urandom_range(1, 128));
    endfunction

    function automatic logic [15:0] random_origin();
        if ($urandom_range(0, 9) < 7)
            return 16'($urandom_range(0, 200));
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic sampler_cfg_t random_config();
        sampler_cfg_t cfg;
        cfg.cell_size    = 8'($urandom_range(0, 255));
        cfg.origin_x     = random_origin();
        cfg.origin_y     = random_origin();
        cfg.image_width  = random_extent();
        cfg.image_height = random_extent();
        cfg.grid_width   = 11'($urandom_range(0, 2047));
        return cfg;
    endfunction

    // Pick a cell whose sample points mostly land inside the loaded image
    // under the current origin and cell size.
    function automatic int aimed_cell(input int origin, input int extent, input int size);
        int target;
        target = (origin + $urandom_range(0, extent + size)) / size;
        return (target > 1023) ? 1023 : target;
    endfunction

    function automatic sampler_cmd_t random_command();
        sampler_cmd_t item;
        int           size;
        item.cmd     = ($urandom_range(0, 1) == 1) ? CMD_SAMPLE : CMD_STORE;
        item.pixel_x = 7'($urandom_range(0, 127));
        item.pixel_y = 7'($urandom_range(0, 127));
        item.red     = 8'($urandom_range(0, 255));
        item.green   = 8'($urandom_range(0, 255));
        item.blue    = 8'($urandom_range(0, 255));
        item.cell_x  = 10'($urandom_range(0, 1023));
        item.cell_y  = 10'($urandom_range(0, 1023));
        size         = int'(color_check.cell_size);
        if (item.cmd == CMD_SAMPLE && size != 0 && $urandom_range(0, 9) < 7) begin
            item.cell_x = 10'(aimed_cell(int'(color_check.origin_x),
                                         int'(color_check.image_width), size));
            item.cell_y = 10'(aimed_cell(int'(color_check.origin_y),
                                         int'(color_check.image_height), size));
        end
        return item;
    endfunction

    initial
    begin
        int phase_end;
        color_check = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings (cell 16, origin 0, 128x128, grid 64).
        // Cell (0,0) reads pixels 4 and 12 in each axis: all full scale.
        send_command(make_store(4, 4, 255, 255, 255));
        send_command(make_store(12, 4, 255, 255, 255));
        send_command(make_store(4, 12, 255, 255, 255));
        send_command(make_store(12, 12, 255, 255, 255));
        send_command(make_sample(0, 0));
        // Cell (1,0): sums of 3, 2 and 1 truncate to zero.
        send_command(make_store(20, 4, 3, 2, 1));
        send_command(make_store(28, 4, 0, 0, 0));
        send_command(make_store(20, 12, 0, 0, 0));
        send_command(make_store(28, 12, 0, 0, 0));
        send_command(make_sample(1, 0));
        // Far corner pixel; cells past the image clamp onto it.
        send_command(make_store(127, 127, 170, 85, 255));
        send_command(make_store(0, 0, 85, 170, 0));
        send_command(make_sample(1023, 1023));
        send_command(make_sample(0, 1023));
        send_command(make_sample(1023, 0));
        send_command(make_sample(7, 7));
        send_command(make_sample(8, 8));
        send_command(make_sample(7, 8));

        // Random part, one setting per phase. Sender gaps: light, then
        // heavy, then none at all.
        for (int phase = 0; phase < PHASE_COUNT; phase++) begin
            drain_results();
            apply_config((phase < 6) ? corner_config(phase) : random_config());
            gap_percent = (phase < 4) ? 9 : ((phase < 8) ? 86 : 0);
            phase_end   = items_sent + ITEMS_PER_PHASE;
            while (items_sent < phase_end) begin
                // now and then let the block run dry mid-phase
                if ($urandom_range(0, 99) == 0)
                    drain_results();
                send_command(random_command());
            end
        end

        drain_results();
        if (color_check.mismatch_count == 0 && color_check.outstanding() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
